// ===== rtl/ubxfp_pkg.sv =====
package ubxfp_pkg;

   // Frame framing bytes
   localparam logic [7:0] SyncFirst  = 8'hB5;
   localparam logic [7:0] SyncSecond = 8'h62;

   // Message classes and ids that the back end acts on
   localparam logic [7:0] ClassNav = 8'h01;
   localparam logic [7:0] IdNavPvt = 8'h07;
   localparam logic [7:0] ClassMon = 8'h0A;
   localparam logic [7:0] IdMonRf  = 8'h38;

   localparam logic [15:0] MinLenNavPvt = 16'd92;
   localparam logic [15:0] MinLenMonRf  = 16'd20;

   // Payload byte offsets read at dispatch
   localparam int OffAgc      = 18;
   localparam int OffFixType  = 20;
   localparam int OffFlags    = 21;
   localparam int OffSats     = 23;
   localparam int OffLon      = 24;
   localparam int OffLat      = 28;
   localparam int OffAlt      = 36;
   localparam int OffHacc     = 40;
   localparam int OffSpeed    = 60;
   localparam int OffHeading  = 64;

   // Window of payload bytes kept in the capture register
   localparam int CapFirst = OffAgc;
   localparam int CapLast  = OffHeading + 3;
   localparam int CapBytes = CapLast - CapFirst + 1;

   // Valid range of fix type for a usable fix
   localparam logic [7:0] FixTypeMin = 8'd2;
   localparam logic [7:0] FixTypeMax = 8'd4;

   // Depth of the queue between parser and status back end
   localparam int QueueDepth = 2;

   typedef enum logic [8:0] {
      PH_HUNT    = 9'b000000001,
      PH_SYNC2   = 9'b000000010,
      PH_CLASS   = 9'b000000100,
      PH_ID      = 9'b000001000,
      PH_LEN_LO  = 9'b000010000,
      PH_LEN_HI  = 9'b000100000,
      PH_PAYLOAD = 9'b001000000,
      PH_CK_A    = 9'b010000000,
      PH_CK_B    = 9'b100000000
   } phase_type;

   typedef enum logic [1:0] {
      CMD_NONE = 2'd0,
      CMD_NAV  = 2'd1,
      CMD_RF   = 2'd2
   } cmd_type;

   typedef struct packed {
      logic        frame_ok;
      logic [15:0] message_type;
      cmd_type     cmd;
   } entry_type;

   typedef struct packed {
      logic [7:0]  fix_mode;
      logic [7:0]  flags;
      logic [7:0]  satellites;
      logic [31:0] longitude;
      logic [31:0] latitude;
      logic [31:0] altitude;
      logic [31:0] horiz_accuracy;
      logic [31:0] ground_speed;
      logic [31:0] heading;
      logic [15:0] agc;
   } capture_type;

endpackage

// ===== rtl/ubxfp_front.sv =====
module ubxfp_front
   import ubxfp_pkg::*;
#(
   parameter int MAX_PAYLOAD = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        accept,
   input  logic [7:0]  rx_byte,
   output entry_type   entry,
   output capture_type capture
);

   localparam int CntW = $clog2(MAX_PAYLOAD + 1);

   phase_type         phase_ff, phase_in;
   logic [7:0]        class_ff, class_in;
   logic [7:0]        id_ff, id_in;
   logic [15:0]       len_ff, len_in;
   logic [CntW-1:0]   cnt_ff, cnt_in;
   logic [7:0]        suma_ff, suma_in;
   logic [7:0]        sumb_ff, sumb_in;
   logic [7:0]        rsum_ff, rsum_in;
   logic [CapBytes*8-1:0] cap_ff;

   logic [7:0]  suma_add;
   logic [7:0]  sumb_add;
   logic [15:0] len_full;
   logic        ok;
   cmd_type     cmd;

   assign suma_add = suma_ff + rx_byte;
   assign sumb_add = sumb_ff + suma_add;
   assign len_full = {rx_byte, len_ff[7:0]};

   always_comb begin
      phase_in = phase_ff;
      class_in = class_ff;
      id_in    = id_ff;
      len_in   = len_ff;
      cnt_in   = cnt_ff;
      suma_in  = suma_ff;
      sumb_in  = sumb_ff;
      rsum_in  = rsum_ff;
      ok       = 1'b0;
      cmd      = CMD_NONE;
      unique case (phase_ff)
         PH_HUNT: begin
            if (rx_byte == SyncFirst) phase_in = PH_SYNC2;
         end
         PH_SYNC2: begin
            if (rx_byte == SyncSecond) begin
               phase_in = PH_CLASS;
               suma_in  = 8'd0;
               sumb_in  = 8'd0;
            end else begin
               phase_in = (rx_byte == SyncFirst) ? PH_SYNC2 : PH_HUNT;
            end
         end
         PH_CLASS: begin
            class_in = rx_byte;
            suma_in  = suma_add;
            sumb_in  = sumb_add;
            phase_in = PH_ID;
         end
         PH_ID: begin
            id_in    = rx_byte;
            suma_in  = suma_add;
            sumb_in  = sumb_add;
            phase_in = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            len_in   = {8'd0, rx_byte};
            suma_in  = suma_add;
            sumb_in  = sumb_add;
            phase_in = PH_LEN_HI;
         end
         PH_LEN_HI: begin
            cnt_in = '0;
            if (len_full > 16'(MAX_PAYLOAD)) begin
               // oversize: drop the frame and clear the parser
               phase_in = PH_HUNT;
               class_in = 8'd0;
               id_in    = 8'd0;
               len_in   = 16'd0;
               suma_in  = 8'd0;
               sumb_in  = 8'd0;
               rsum_in  = 8'd0;
            end else begin
               len_in   = len_full;
               suma_in  = suma_add;
               sumb_in  = sumb_add;
               phase_in = (len_full == 16'd0) ? PH_CK_A : PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            cnt_in  = cnt_ff + 1'b1;
            suma_in = suma_add;
            sumb_in = sumb_add;
            if (16'(cnt_in) >= len_ff) phase_in = PH_CK_A;
         end
         PH_CK_A: begin
            rsum_in  = rx_byte;
            phase_in = PH_CK_B;
         end
         PH_CK_B: begin
            ok       = (rsum_ff == suma_ff) && (rx_byte == sumb_ff);
            phase_in = PH_HUNT;
            if (ok) begin
               if (class_ff == ClassNav && id_ff == IdNavPvt && len_ff >= MinLenNavPvt) begin
                  cmd = CMD_NAV;
               end else if (class_ff == ClassMon && id_ff == IdMonRf &&
                            len_ff >= MinLenMonRf) begin
                  cmd = CMD_RF;
               end
            end
         end
         default: begin
            phase_in = PH_HUNT;
            class_in = 8'd0;
            id_in    = 8'd0;
            len_in   = 16'd0;
            cnt_in   = '0;
            suma_in  = 8'd0;
            sumb_in  = 8'd0;
            rsum_in  = 8'd0;
         end
      endcase
   end

   assign entry.frame_ok     = ok;
   assign entry.message_type = {class_in, id_in};
   assign entry.cmd          = cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         class_ff <= 8'd0;
         id_ff    <= 8'd0;
         len_ff   <= 16'd0;
         cnt_ff   <= '0;
         suma_ff  <= 8'd0;
         sumb_ff  <= 8'd0;
         rsum_ff  <= 8'd0;
      end else if (accept) begin
         phase_ff <= phase_in;
         class_ff <= class_in;
         id_ff    <= id_in;
         len_ff   <= len_in;
         cnt_ff   <= cnt_in;
         suma_ff  <= suma_in;
         sumb_ff  <= sumb_in;
         rsum_ff  <= rsum_in;
      end
   end

   // Keep only the payload bytes that dispatch reads
   always_ff @(posedge clock) begin
      if (accept && phase_ff == PH_PAYLOAD) begin
         for (int k = 0; k < CapBytes; k++) begin
            if (cnt_ff == CntW'(CapFirst + k)) cap_ff[k*8 +: 8] <= rx_byte;
         end
      end
   end

   assign capture.agc            = cap_ff[(OffAgc - CapFirst)*8 +: 16];
   assign capture.fix_mode       = cap_ff[(OffFixType - CapFirst)*8 +: 8];
   assign capture.flags          = cap_ff[(OffFlags - CapFirst)*8 +: 8];
   assign capture.satellites     = cap_ff[(OffSats - CapFirst)*8 +: 8];
   assign capture.longitude      = cap_ff[(OffLon - CapFirst)*8 +: 32];
   assign capture.latitude       = cap_ff[(OffLat - CapFirst)*8 +: 32];
   assign capture.altitude       = cap_ff[(OffAlt - CapFirst)*8 +: 32];
   assign capture.horiz_accuracy = cap_ff[(OffHacc - CapFirst)*8 +: 32];
   assign capture.ground_speed   = cap_ff[(OffSpeed - CapFirst)*8 +: 32];
   assign capture.heading        = cap_ff[(OffHeading - CapFirst)*8 +: 32];

endmodule

// ===== rtl/ubxfp_queue.sv =====
module ubxfp_queue
   import ubxfp_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_data,
   input  logic      pop,
   output logic      full,
   output logic      not_empty,
   output entry_type pop_data
);

   localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int CntW = $clog2(QueueDepth + 1);

   entry_type       mem_ff [QueueDepth];
   logic [PtrW-1:0] wr_ff, wr_in;
   logic [PtrW-1:0] rd_ff, rd_in;
   logic [CntW-1:0] cnt_ff, cnt_in;

   assign full      = (cnt_ff == CntW'(QueueDepth));
   assign not_empty = (cnt_ff != '0);
   assign pop_data  = mem_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) wr_in = (wr_ff == PtrW'(QueueDepth - 1)) ? '0 : wr_ff + 1'b1;
      if (pop)  rd_in = (rd_ff == PtrW'(QueueDepth - 1)) ? '0 : rd_ff + 1'b1;
      if (push && !pop)      cnt_in = cnt_ff + 1'b1;
      else if (pop && !push) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_data;
   end

endmodule

// ===== rtl/ubxfp_back.sv =====
module ubxfp_back
   import ubxfp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        q_not_empty,
   input  entry_type   q_data,
   output logic        q_pop,
   input  capture_type capture,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_frame_ok,
   output logic [15:0] rsp_message_type,
   output logic        rsp_fix_good,
   output logic [7:0]  rsp_fix_mode,
   output logic [7:0]  rsp_satellites,
   output logic [31:0] rsp_longitude,
   output logic [31:0] rsp_latitude,
   output logic [31:0] rsp_altitude,
   output logic [31:0] rsp_horiz_accuracy_mm,
   output logic [31:0] rsp_ground_speed,
   output logic [31:0] rsp_heading,
   output logic [15:0] rsp_rf_agc
);

   logic        valid_ff;
   logic        ok_ff;
   logic [15:0] msg_ff;
   logic        fix_good_ff;
   logic [7:0]  fix_mode_ff;
   logic [7:0]  sats_ff;
   logic [31:0] lon_ff, lat_ff, alt_ff, hacc_ff, speed_ff, heading_ff;
   logic [15:0] agc_ff;
   logic        fix_ok;

   assign q_pop  = q_not_empty && (!valid_ff || rsp_ready);
   assign fix_ok = capture.flags[0] && (capture.fix_mode >= FixTypeMin) &&
                   (capture.fix_mode <= FixTypeMax);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (q_pop) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         ok_ff  <= q_data.frame_ok;
         msg_ff <= q_data.message_type;
      end
   end

   // Status registers change only as a new transaction loads the output
   always_ff @(posedge clock) begin
      if (reset) begin
         fix_good_ff  <= 1'b0;
         fix_mode_ff  <= 8'd0;
         sats_ff      <= 8'd0;
         lon_ff       <= 32'd0;
         lat_ff       <= 32'd0;
         alt_ff       <= 32'd0;
         hacc_ff      <= 32'd0;
         speed_ff     <= 32'd0;
         heading_ff   <= 32'd0;
         agc_ff       <= 16'd0;
      end else if (q_pop) begin
         unique case (q_data.cmd)
            CMD_NAV: begin
               fix_good_ff  <= fix_ok;
               fix_mode_ff  <= capture.fix_mode;
               sats_ff      <= capture.satellites;
               lon_ff       <= capture.longitude;
               lat_ff       <= capture.latitude;
               alt_ff       <= capture.altitude;
               hacc_ff      <= capture.horiz_accuracy;
               speed_ff     <= capture.ground_speed;
               heading_ff   <= capture.heading;
            end
            CMD_RF: begin
               agc_ff <= capture.agc;
            end
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid             = valid_ff;
   assign rsp_frame_ok          = ok_ff;
   assign rsp_message_type      = msg_ff;
   assign rsp_fix_good          = fix_good_ff;
   assign rsp_fix_mode          = fix_mode_ff;
   assign rsp_satellites        = sats_ff;
   assign rsp_longitude         = lon_ff;
   assign rsp_latitude          = lat_ff;
   assign rsp_altitude          = alt_ff;
   assign rsp_horiz_accuracy_mm = hacc_ff;
   assign rsp_ground_speed      = speed_ff;
   assign rsp_heading           = heading_ff;
   assign rsp_rf_agc            = agc_ff;

endmodule

// ===== rtl/ubx_frame_parser_status_capture_top.sv =====
// Binary frame parser with navigation and RF status capture. Each request
// transaction carries one byte from the receiver's serial link; every byte
// yields exactly one response transaction holding frame_ok (set when that
// byte closed a frame with a matching two-byte running checksum), the class
// and id of the frame being parsed, and the status registers as they stand
// after the byte. A good navigation frame (class 0x01, id 0x07, at least 92
// payload bytes) reloads fix, satellite, position, altitude, accuracy, speed
// and heading; a good RF monitor frame (class 0x0A, id 0x38, at least 20
// payload bytes) reloads the AGC word. A frame longer than MAX_PAYLOAD is
// dropped at its length field. Throughput is one byte per clock while the
// queue has room; a response is presented once its byte's queue entry,
// written at the accepting edge, has moved from the queue head into the
// free output register. req_ready drops only while the two-entry queue is
// full because the response side is stalled.
module ubx_frame_parser_status_capture_top
   import ubxfp_pkg::*;
#(
   parameter int MAX_PAYLOAD = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_frame_ok,
   output logic [15:0] rsp_message_type,
   output logic        rsp_fix_good,
   output logic [7:0]  rsp_fix_mode,
   output logic [7:0]  rsp_satellites,
   output logic [31:0] rsp_longitude,
   output logic [31:0] rsp_latitude,
   output logic [31:0] rsp_altitude,
   output logic [31:0] rsp_horiz_accuracy_mm,
   output logic [31:0] rsp_ground_speed,
   output logic [31:0] rsp_heading,
   output logic [15:0] rsp_rf_agc
);

   logic        accept;
   logic        q_full;
   logic        q_not_empty;
   logic        q_pop;
   entry_type   push_entry;
   entry_type   pop_entry;
   capture_type capture;

   // Take a byte whenever the queue has room
   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;

   // Front end: sync hunt, header, checksum, payload capture; classify each
   // byte into a queue entry.
   ubxfp_front #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .rx_byte (req_rx_byte),
      .entry   (push_entry),
      .capture (capture)
   );

   // The back end reads the capture window when it pops a dispatch entry.
   // A later frame needs far more bytes than the queue can hold before it
   // reaches any captured offset, so the window is still intact then.
   ubxfp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (push_entry),
      .pop       (q_pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .pop_data  (pop_entry)
   );

   // Back end: apply the dispatch and hold the response transaction.
   ubxfp_back u_back (
      .clock                 (clock),
      .reset                 (reset),
      .q_not_empty           (q_not_empty),
      .q_data                (pop_entry),
      .q_pop                 (q_pop),
      .capture               (capture),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_frame_ok          (rsp_frame_ok),
      .rsp_message_type      (rsp_message_type),
      .rsp_fix_good          (rsp_fix_good),
      .rsp_fix_mode          (rsp_fix_mode),
      .rsp_satellites        (rsp_satellites),
      .rsp_longitude         (rsp_longitude),
      .rsp_latitude          (rsp_latitude),
      .rsp_altitude          (rsp_altitude),
      .rsp_horiz_accuracy_mm (rsp_horiz_accuracy_mm),
      .rsp_ground_speed      (rsp_ground_speed),
      .rsp_heading           (rsp_heading),
      .rsp_rf_agc            (rsp_rf_agc)
   );

endmodule
